### src/pmvm_pkg.sv
// Package for the power-mode vote manager: action and mode codes,
// field widths and the slot allocator result type.
// No dependencies.
`default_nettype none

package pmvm_pkg;

    // Field widths of the command and result words
    localparam int ACTION_W  = 3;
    localparam int ID_W      = 6;
    localparam int MODE_W    = 3;

    // Mask words are 32 bits; at most 64 client slots exist
    localparam int WORD_BITS = 32;
    localparam int MAX_SLOTS = 64;

    // Command codes
    typedef enum logic [ACTION_W-1:0] {
        ACT_REGISTER   = 3'd0,
        ACT_UNREGISTER = 3'd1,
        ACT_ENABLE     = 3'd2,
        ACT_DISABLE    = 3'd3,
        ACT_ENTER      = 3'd4
    } action_t;

    // Power modes, shallow to deep
    localparam logic [MODE_W-1:0] MODE_RUN   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_LPRUN = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SLEEP = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DEEP  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_OFF   = 3'd4;

    // Lowest free slot search result
    typedef struct packed {
        logic            found;
        logic [ID_W-1:0] slot;
    } alloc_t;

endpackage

`default_nettype wire

### src/power_mode_vote_manager.sv
// Power-mode vote manager top level: command register, slot/veto masks,
// result register. Depends on pmvm_pkg and pmvm_alloc.
//
//   channel  | ports                              | handshake
//   ---------+------------------------------------+---------------------------
//   command  | action, client_id, mode            | start && !busy
//   result   | ok, assigned_id, mode_valid,       | done, one cycle strobe
//            | mode_out                           |
//
// A command is taken into the input register, evaluated against the masks in
// the next cycle, and its result word is strobed on done the cycle after
// that; one command per cycle is sustained. busy is never
// raised. The result receiver cannot stall; every result is shown for exactly
// one cycle. rst_n clears all masks (no slots registered) and the strobes.
`default_nettype none

module power_mode_vote_manager #(
    parameter int MASK_WORDS = 2
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [pmvm_pkg::ACTION_W-1:0] action,
    input  wire logic [pmvm_pkg::ID_W-1:0]     client_id,
    input  wire logic [pmvm_pkg::MODE_W-1:0]   mode,
    output logic                               done,
    output logic                               ok,
    output logic [pmvm_pkg::ID_W-1:0]          assigned_id,
    output logic                               mode_valid,
    output logic [pmvm_pkg::MODE_W-1:0]        mode_out
);
    import pmvm_pkg::*;

    localparam int NUM_SLOTS = (MASK_WORDS * WORD_BITS > MAX_SLOTS) ?
                               MAX_SLOTS : MASK_WORDS * WORD_BITS;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);

    // Input register
    logic                in_valid_reg;
    logic [ACTION_W-1:0] action_reg;
    logic [ID_W-1:0]     id_reg;
    logic [MODE_W-1:0]   mode_reg;

    // Client masks
    logic [NUM_SLOTS-1:0] used_reg,  used_next;
    logic [NUM_SLOTS-1:0] run_reg,   run_next;
    logic [NUM_SLOTS-1:0] lprun_reg, lprun_next;
    logic [NUM_SLOTS-1:0] sleep_reg, sleep_next;
    logic [NUM_SLOTS-1:0] deep_reg,  deep_next;
    logic [NUM_SLOTS-1:0] off_reg,   off_next;

    // Result register
    logic              done_reg;
    logic              ok_reg,       ok_next;
    logic [ID_W-1:0]   assigned_reg, assigned_next;
    logic              mvalid_reg,   mvalid_next;
    logic [MODE_W-1:0] mout_reg,     mout_next;

    alloc_t               alloc;
    logic                 id_ok;
    logic [NUM_SLOTS-1:0] id_bit;
    logic [NUM_SLOTS-1:0] alloc_bit;

    assign busy = 1'b0;

    pmvm_alloc #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_alloc (
        .used  (used_reg),
        .alloc (alloc)
    );

    // Capture command word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            action_reg <= action;
            id_reg     <= client_id;
            mode_reg   <= mode;
        end
    end

    // Slot decode
    assign id_ok     = {1'b0, id_reg} < (ID_W + 1)'(NUM_SLOTS);
    assign id_bit    = NUM_SLOTS'(1) << id_reg[SLOT_W-1:0];
    assign alloc_bit = NUM_SLOTS'(1) << alloc.slot[SLOT_W-1:0];

    // Command evaluation and mask update
    always_comb
    begin
        used_next     = used_reg;
        run_next      = run_reg;
        lprun_next    = lprun_reg;
        sleep_next    = sleep_reg;
        deep_next     = deep_reg;
        off_next      = off_reg;
        ok_next       = 1'b0;
        assigned_next = '0;
        mvalid_next   = 1'b0;
        mout_next     = MODE_RUN;

        if (in_valid_reg)
        begin
            case (action_reg)
                ACT_REGISTER:
                begin
                    if (alloc.found)
                    begin
                        used_next     = used_reg  | alloc_bit;
                        run_next      = run_reg   | alloc_bit;
                        lprun_next    = lprun_reg & ~alloc_bit;
                        sleep_next    = sleep_reg & ~alloc_bit;
                        deep_next     = deep_reg  & ~alloc_bit;
                        off_next      = off_reg   & ~alloc_bit;
                        ok_next       = 1'b1;
                        assigned_next = alloc.slot;
                    end
                end
                ACT_UNREGISTER:
                begin
                    if (id_ok)
                    begin
                        used_next = used_reg & ~id_bit;
                        ok_next   = 1'b1;
                    end
                end
                ACT_ENABLE:
                begin
                    if (id_ok)
                    begin
                        ok_next = 1'b1;
                        case (mode_reg)
                            MODE_RUN:   run_next   = run_reg   | id_bit;
                            MODE_LPRUN: lprun_next = lprun_reg & ~id_bit;
                            MODE_SLEEP: sleep_next = sleep_reg & ~id_bit;
                            MODE_DEEP:  deep_next  = deep_reg  & ~id_bit;
                            MODE_OFF:   off_next   = off_reg   & ~id_bit;
                            default:    ;
                        endcase
                    end
                end
                ACT_DISABLE:
                begin
                    if (id_ok)
                    begin
                        ok_next = 1'b1;
                        case (mode_reg)
                            MODE_RUN:   run_next   = run_reg   & ~id_bit;
                            MODE_LPRUN: lprun_next = lprun_reg | id_bit;
                            MODE_SLEEP: sleep_next = sleep_reg | id_bit;
                            MODE_DEEP:  deep_next  = deep_reg  | id_bit;
                            MODE_OFF:   off_next   = off_reg   | id_bit;
                            default:    ;
                        endcase
                    end
                end
                ACT_ENTER:
                begin
                    // Any run demand blocks low power; else deepest unvetoed mode
                    if (|(used_reg & run_reg))
                        ok_next = 1'b1;
                    else if (!(|(used_reg & off_reg)))
                    begin
                        ok_next     = 1'b1;
                        mvalid_next = 1'b1;
                        mout_next   = MODE_OFF;
                    end
                    else if (!(|(used_reg & deep_reg)))
                    begin
                        ok_next     = 1'b1;
                        mvalid_next = 1'b1;
                        mout_next   = MODE_DEEP;
                    end
                    else if (!(|(used_reg & sleep_reg)))
                    begin
                        ok_next     = 1'b1;
                        mvalid_next = 1'b1;
                        mout_next   = MODE_SLEEP;
                    end
                    else if (!(|(used_reg & lprun_reg)))
                    begin
                        ok_next     = 1'b1;
                        mvalid_next = 1'b1;
                        mout_next   = MODE_LPRUN;
                    end
                end
                default: ;
            endcase
        end
    end

    // Mask and strobe registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= '0;
            run_reg   <= '0;
            lprun_reg <= '0;
            sleep_reg <= '0;
            deep_reg  <= '0;
            off_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            used_reg  <= used_next;
            run_reg   <= run_next;
            lprun_reg <= lprun_next;
            sleep_reg <= sleep_next;
            deep_reg  <= deep_next;
            off_reg   <= off_next;
            done_reg  <= in_valid_reg;
        end
    end

    // Result word
    always_ff @(posedge clk)
    begin
        ok_reg       <= ok_next;
        assigned_reg <= assigned_next;
        mvalid_reg   <= mvalid_next;
        mout_reg     <= mout_next;
    end

    assign done        = done_reg;
    assign ok          = ok_reg;
    assign assigned_id = assigned_reg;
    assign mode_valid  = mvalid_reg;
    assign mode_out    = mout_reg;

`ifndef ASSERT_OFF
    // A result strobe always follows an evaluated command
    a_done_follows_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(in_valid_reg))
        else $error("result strobe without a command");

    // An applied mode is always a success and never plain run
    a_mode_implies_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && mvalid_reg) |-> (ok_reg && mout_reg != MODE_RUN))
        else $error("mode applied without success or as run");

    // A granted slot is marked used with run demand afterwards
    a_alloc_marks_used: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && action_reg == ACT_REGISTER && alloc.found) |=>
        (used_reg[assigned_reg[SLOT_W-1:0]] && run_reg[assigned_reg[SLOT_W-1:0]]))
        else $error("granted slot not marked used");
`endif

endmodule

`default_nettype wire

### src/pmvm_alloc.sv
// Lowest free client slot finder for the power-mode vote manager.
// Depends on pmvm_pkg (alloc_t, ID_W).
`default_nettype none

module pmvm_alloc #(
    parameter int NUM_SLOTS = 64
) (
    input  wire logic [NUM_SLOTS-1:0] used,
    output pmvm_pkg::alloc_t          alloc
);
    import pmvm_pkg::*;

    // Priority encoder: scan from the top so the lowest free slot wins
    always_comb
    begin
        alloc.found = 1'b0;
        alloc.slot  = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (!used[i])
            begin
                alloc.found = 1'b1;
                alloc.slot  = ID_W'(i);
            end
        end
    end

endmodule

`default_nettype wire
